FILE: hw/rtl/rhsm_pkg.sv
// Shared types and constants for the rolling hash string matcher.
`default_nettype none

package rhsm_pkg;

    localparam int SYM_W   = 8;
    localparam int PIDX_W  = 6;
    localparam int HASH_W  = 16;
    localparam int RADIX_W = 9;
    localparam int PLEN_W  = 7;
    localparam int CNT_W   = 17;
    localparam int RED_W   = 32;

    localparam logic [SYM_W-1:0] ZERO_CODE = 8'd48;
    localparam logic [CNT_W-1:0] COUNT_CAP = 17'h10000;

    typedef enum logic [1:0] {
        FN_LOAD    = 2'd0,
        FN_TEXT    = 2'd1,
        FN_RESTART = 2'd2,
        FN_NOP     = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        CFG_RADIX   = 2'd0,
        CFG_MODULUS = 2'd1,
        CFG_PLEN    = 2'd2,
        CFG_NONE    = 2'd3
    } cfg_idx_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic              pat_we;
        logic [PIDX_W-1:0] pidx;
        logic [SYM_W-1:0]  sym;
        logic              win_shift;
        logic              tap_load_win;
        logic              tap_load_pat;
        logic              tap_shift;
    } rhsm_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rolling_hash_string_matcher.sv
// Top level: Rabin-Karp matcher with a row of symbol cells and a serial reducer.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | sink      | in_valid / in_ready  | func, symbol, pattern_index, end_of_text
//  out     | source    | out_valid / out_ready| match_found, match_start, match_total,
//          |           |                      | last_start, any_match, text_done
//  cfg     | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One word at a time. Each modular reduction runs in the bit-serial reducer.
// Pattern load: up to 5 reductions. Restart and no-op: no reduction.
// Text word: up to 8 reductions plus up to MAX_PATTERN-1 tap shifts.
// Reset clears hashes, counts and the output valid flag; cell contents are not cleared.
// A held output word stalls only the final step; the next input waits for the idle state.
`default_nettype none

module rolling_hash_string_matcher #(
    parameter int MAX_PATTERN = 64,
    parameter int MAX_TEXT    = 65536
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    func,
    input  wire logic [rhsm_pkg::SYM_W-1:0]    symbol,
    input  wire logic [rhsm_pkg::PIDX_W-1:0]   pattern_index,
    input  wire logic                          end_of_text,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               match_found,
    output logic [15:0]                        match_start,
    output logic [rhsm_pkg::CNT_W-1:0]         match_total,
    output logic [15:0]                        last_start,
    output logic                               any_match,
    output logic                               text_done,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [15:0]                   cfg_data
);
    import rhsm_pkg::*;

    localparam int MW  = $clog2(MAX_PATTERN + 1);
    localparam int PSW = $clog2(MAX_TEXT + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_WAIT,
        S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7,
        S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_T7, S_T7B,
        S_T8, S_T9, S_T10, S_T11, S_T12,
        S_FIN
    } state_t;

    state_t            state_reg;
    state_t            ret_reg;

    logic [RADIX_W-1:0] radix_reg;
    logic [HASH_W-1:0]  modulus_reg;
    logic [PLEN_W-1:0]  plen_reg;

    func_t              func_reg;
    logic [SYM_W-1:0]   sym_reg;
    logic [PIDX_W-1:0]  pidx_reg;
    logic               eot_reg;

    logic [HASH_W-1:0]  ph_reg;
    logic [HASH_W-1:0]  th_reg;
    logic [HASH_W-1:0]  rp_reg;
    logic [PSW-1:0]     pos_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [15:0]        last_reg;
    logic               seen_reg;

    logic [HASH_W-1:0]  a_reg;
    logic [HASH_W-1:0]  v_reg;
    logic [HASH_W-1:0]  t_reg;
    logic [HASH_W-1:0]  sv_reg;
    logic [RED_W-1:0]   prod_reg;
    logic [MW-1:0]      cnt_reg;
    logic               found_reg;
    logic [15:0]        start_reg;
    logic               done_reg;

    logic               mod_start_reg;
    logic [RED_W-1:0]   mod_x_reg;
    logic               mod_done;
    logic [HASH_W-1:0]  mod_rem;

    logic               out_valid_reg;
    logic               out_found_reg;
    logic [15:0]        out_start_reg;
    logic [CNT_W-1:0]   out_total_reg;
    logic [15:0]        out_last_reg;
    logic               out_any_reg;
    logic               out_done_reg;

    logic [HASH_W-1:0]  qe;
    logic [MW-1:0]      m_eff;
    logic [RED_W-1:0]   q48;
    logic [RED_W-1:0]   start_calc;
    logic [HASH_W-1:0]  mul_a;
    logic [HASH_W-1:0]  mul_b;
    rhsm_ctl_t          ctl;
    logic               match_all;

    logic [SYM_W-1:0]       w_arr [MAX_PATTERN];
    logic [SYM_W-1:0]       t_arr [MAX_PATTERN];
    logic [SYM_W-1:0]       p_arr [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] eq_vec;

    assign qe  = (modulus_reg == '0) ? HASH_W'(1) : modulus_reg;
    assign q48 = ({16'b0, qe} << 5) + ({16'b0, qe} << 4);
    assign start_calc = RED_W'(pos_reg) + RED_W'(1) - RED_W'(m_eff);

    always_comb
    begin
        if (plen_reg == '0)
        begin
            m_eff = MW'(1);
        end
        else if (int'(plen_reg) > MAX_PATTERN)
        begin
            m_eff = MW'(MAX_PATTERN);
        end
        else
        begin
            m_eff = MW'(plen_reg);
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_P2, S_P5:
            begin
                mul_a = HASH_W'(radix_reg);
                mul_b = a_reg;
            end
            S_T5:
            begin
                mul_a = sv_reg;
                mul_b = a_reg;
            end
            S_T8:
            begin
                mul_a = HASH_W'(radix_reg);
                mul_b = t_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        ctl           = '0;
        ctl.pidx      = pidx_reg;
        ctl.sym       = sym_reg;
        ctl.pat_we    = (state_reg == S_DISP) && (func_reg == FN_LOAD)
                        && (int'(pidx_reg) < MAX_PATTERN);
        ctl.win_shift = (state_reg == S_T10);
        ctl.tap_load_win = (state_reg == S_T2) && (int'(pos_reg) >= int'(m_eff));
        ctl.tap_load_pat = (state_reg == S_T11) && (a_reg == t_reg);
        ctl.tap_shift = ((state_reg == S_T3) || (state_reg == S_T12)) && (cnt_reg != '0);
    end

    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++)
        begin : g_cell
            logic [SYM_W-1:0] w_in;
            logic [SYM_W-1:0] t_in;
            logic             act;

            if (k == 0)
            begin : g_first
                assign w_in = sym_reg;
            end
            else
            begin : g_mid
                assign w_in = w_arr[k-1];
            end

            if (k == MAX_PATTERN - 1)
            begin : g_last
                assign t_in = '0;
            end
            else
            begin : g_up
                assign t_in = t_arr[k+1];
            end

            assign act = (k < int'(m_eff));

            rhsm_cell #(
                .IDX (k)
            ) u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .active   (act),
                .w_prev   (w_in),
                .t_above  (t_in),
                .p_mirror (p_arr[MAX_PATTERN-1-k]),
                .w_q      (w_arr[k]),
                .t_q      (t_arr[k]),
                .p_q      (p_arr[k]),
                .eq       (eq_vec[k])
            );
        end
    endgenerate

    assign match_all = &eq_vec;

    rhsm_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start_reg),
        .x     (mod_x_reg),
        .q     (qe),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    assign in_ready    = (state_reg == S_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign match_found = out_found_reg;
    assign match_start = out_start_reg;
    assign match_total = out_total_reg;
    assign last_start  = out_last_reg;
    assign any_match   = out_any_reg;
    assign text_done   = out_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            radix_reg     <= RADIX_W'(10);
            modulus_reg   <= HASH_W'(13);
            plen_reg      <= PLEN_W'(1);
            ph_reg        <= '0;
            th_reg        <= '0;
            rp_reg        <= HASH_W'(1);
            pos_reg       <= '0;
            count_reg     <= '0;
            last_reg      <= '0;
            seen_reg      <= 1'b0;
            mod_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            mod_start_reg <= 1'b0;

            if (cfg_valid)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_RADIX:   radix_reg   <= cfg_data[RADIX_W-1:0];
                    CFG_MODULUS: modulus_reg <= cfg_data;
                    CFG_PLEN:    plen_reg    <= cfg_data[PLEN_W-1:0];
                    default:     ;
                endcase
            end

            // in S_FIN the output register is reloaded below instead
            if (out_valid_reg && out_ready && (state_reg != S_FIN))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        func_reg  <= func_t'(func);
                        sym_reg   <= symbol;
                        pidx_reg  <= pattern_index;
                        eot_reg   <= end_of_text;
                        found_reg <= 1'b0;
                        start_reg <= '0;
                        done_reg  <= 1'b0;
                        state_reg <= S_DISP;
                    end
                end
                S_DISP:
                begin
                    state_reg <= S_FIN;
                    case (func_reg)
                        FN_LOAD:
                        begin
                            if ((int'(pidx_reg) < MAX_PATTERN)
                                && (int'(pidx_reg) < int'(m_eff)))
                            begin
                                mod_start_reg <= 1'b1;
                                mod_x_reg <= RED_W'(sym_reg) + q48 - RED_W'(ZERO_CODE);
                                ret_reg   <= S_P1;
                                state_reg <= S_WAIT;
                            end
                        end
                        FN_TEXT:
                        begin
                            done_reg <= eot_reg;
                            if (int'(pos_reg) < MAX_TEXT)
                            begin
                                mod_start_reg <= 1'b1;
                                mod_x_reg <= RED_W'(sym_reg) + q48 - RED_W'(ZERO_CODE);
                                ret_reg   <= S_T1;
                                state_reg <= S_WAIT;
                            end
                        end
                        FN_RESTART:
                        begin
                            th_reg    <= '0;
                            pos_reg   <= '0;
                            count_reg <= '0;
                            last_reg  <= '0;
                            seen_reg  <= 1'b0;
                        end
                        default:
                        begin
                            state_reg <= S_FIN;
                        end
                    endcase
                end
                S_WAIT:
                begin
                    if (mod_done)
                    begin
                        a_reg     <= mod_rem;
                        state_reg <= ret_reg;
                    end
                end
                // pattern load
                S_P1:
                begin
                    v_reg <= a_reg;
                    if (pidx_reg == '0)
                    begin
                        ph_reg    <= a_reg;
                        rp_reg    <= (qe == HASH_W'(1)) ? '0 : HASH_W'(1);
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        mod_start_reg <= 1'b1;
                        mod_x_reg     <= RED_W'(ph_reg);
                        ret_reg       <= S_P2;
                        state_reg     <= S_WAIT;
                    end
                end
                S_P2:
                begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= S_P3;
                end
                S_P3:
                begin
                    mod_start_reg <= 1'b1;
                    mod_x_reg     <= prod_reg + RED_W'(v_reg);
                    ret_reg       <= S_P4;
                    state_reg     <= S_WAIT;
                end
                S_P4:
                begin
                    ph_reg        <= a_reg;
                    mod_start_reg <= 1'b1;
                    mod_x_reg     <= RED_W'(rp_reg);
                    ret_reg       <= S_P5;
                    state_reg     <= S_WAIT;
                end
                S_P5:
                begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= S_P6;
                end
                S_P6:
                begin
                    mod_start_reg <= 1'b1;
                    mod_x_reg     <= prod_reg;
                    ret_reg       <= S_P7;
                    state_reg     <= S_WAIT;
                end
                S_P7:
                begin
                    rp_reg    <= a_reg;
                    state_reg <= S_FIN;
                end
                // text symbol
                S_T1:
                begin
                    v_reg         <= a_reg;
                    mod_start_reg <= 1'b1;
                    mod_x_reg     <= RED_W'(th_reg);
                    ret_reg       <= S_T2;
                    state_reg     <= S_WAIT;
                end
                S_T2:
                begin
                    t_reg <= a_reg;
                    if (int'(pos_reg) >= int'(m_eff))
                    begin
                        cnt_reg   <= m_eff - MW'(1);
                        state_reg <= S_T3;
                    end
                    else
                    begin
                        state_reg <= S_T8;
                    end
                end
                S_T3:
                begin
                    // tap 0 walks down to the symbol leaving the window
                    if (cnt_reg != '0)
                    begin
                        cnt_reg <= cnt_reg - MW'(1);
                    end
                    else
                    begin
                        mod_start_reg <= 1'b1;
                        mod_x_reg <= RED_W'(t_arr[0]) + q48 - RED_W'(ZERO_CODE);
                        ret_reg   <= S_T4;
                        state_reg <= S_WAIT;
                    end
                end
                S_T4:
                begin
                    sv_reg        <= a_reg;
                    mod_start_reg <= 1'b1;
                    mod_x_reg     <= RED_W'(rp_reg);
                    ret_reg       <= S_T5;
                    state_reg     <= S_WAIT;
                end
                S_T5:
                begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= S_T6;
                end
                S_T6:
                begin
                    mod_start_reg <= 1'b1;
                    mod_x_reg     <= prod_reg;
                    ret_reg       <= S_T7;
                    state_reg     <= S_WAIT;
                end
                S_T7:
                begin
                    mod_start_reg <= 1'b1;
                    mod_x_reg     <= RED_W'(t_reg) + RED_W'(qe) - RED_W'(a_reg);
                    ret_reg       <= S_T7B;
                    state_reg     <= S_WAIT;
                end
                S_T7B:
                begin
                    t_reg     <= a_reg;
                    state_reg <= S_T8;
                end
                S_T8:
                begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= S_T9;
                end
                S_T9:
                begin
                    mod_start_reg <= 1'b1;
                    mod_x_reg     <= prod_reg + RED_W'(v_reg);
                    ret_reg       <= S_T10;
                    state_reg     <= S_WAIT;
                end
                S_T10:
                begin
                    th_reg  <= a_reg;
                    t_reg   <= a_reg;
                    pos_reg <= pos_reg + PSW'(1);
                    if ((int'(pos_reg) + 1) >= int'(m_eff))
                    begin
                        start_reg     <= start_calc[15:0];
                        mod_start_reg <= 1'b1;
                        mod_x_reg     <= RED_W'(ph_reg);
                        ret_reg       <= S_T11;
                        state_reg     <= S_WAIT;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_T11:
                begin
                    if (a_reg == t_reg)
                    begin
                        cnt_reg   <= MW'(MAX_PATTERN) - m_eff;
                        state_reg <= S_T12;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_T12:
                begin
                    // reversed pattern slides down until it lines up with the window
                    if (cnt_reg != '0)
                    begin
                        cnt_reg <= cnt_reg - MW'(1);
                    end
                    else
                    begin
                        if (match_all)
                        begin
                            found_reg <= 1'b1;
                            if (count_reg != COUNT_CAP)
                            begin
                                count_reg <= count_reg + CNT_W'(1);
                            end
                            last_reg <= start_reg;
                            seen_reg <= 1'b1;
                        end
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_found_reg <= found_reg;
                        out_start_reg <= start_reg;
                        out_total_reg <= count_reg;
                        out_last_reg  <= last_reg;
                        out_any_reg   <= seen_reg;
                        out_done_reg  <= done_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_rem_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (mod_rem < qe))
        else $error("reducer remainder not below modulus");

    a_total_capped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (match_total <= COUNT_CAP))
        else $error("match count beyond cap");

    a_found_sets_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && match_found) |-> (any_match && (last_start == match_start)))
        else $error("match word without matching last start");

    a_found_is_text: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && found_reg) |-> (func_reg == FN_TEXT))
        else $error("match reported for a non-text word");

endmodule

`default_nettype wire

FILE: hw/rtl/rhsm_cell.sv
// One cell: pattern symbol, window symbol and tap symbol with local compare.
`default_nettype none

module rhsm_cell #(
    parameter int IDX = 0
) (
    input  wire logic                     clk,
    input  wire rhsm_pkg::rhsm_ctl_t      ctl,
    input  wire logic                     active,
    input  wire logic [rhsm_pkg::SYM_W-1:0] w_prev,
    input  wire logic [rhsm_pkg::SYM_W-1:0] t_above,
    input  wire logic [rhsm_pkg::SYM_W-1:0] p_mirror,
    output logic [rhsm_pkg::SYM_W-1:0]      w_q,
    output logic [rhsm_pkg::SYM_W-1:0]      t_q,
    output logic [rhsm_pkg::SYM_W-1:0]      p_q,
    output logic                            eq
);
    import rhsm_pkg::*;

    logic [SYM_W-1:0] pat_reg;
    logic [SYM_W-1:0] win_reg;
    logic [SYM_W-1:0] tap_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.pat_we && (int'(ctl.pidx) == IDX))
        begin
            pat_reg <= ctl.sym;
        end
        if (ctl.win_shift)
        begin
            win_reg <= w_prev;
        end
        if (ctl.tap_load_win)
        begin
            tap_reg <= win_reg;
        end
        else if (ctl.tap_load_pat)
        begin
            tap_reg <= p_mirror;
        end
        else if (ctl.tap_shift)
        begin
            tap_reg <= t_above;
        end
    end

    assign w_q = win_reg;
    assign t_q = tap_reg;
    assign p_q = pat_reg;
    assign eq  = !active || (win_reg == tap_reg);

endmodule

`default_nettype wire

FILE: hw/rtl/rhsm_mod.sv
// Bit-serial remainder unit: x mod q, one dividend bit per cycle.
`default_nettype none

module rhsm_mod (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [rhsm_pkg::RED_W-1:0]  x,
    input  wire logic [rhsm_pkg::HASH_W-1:0] q,
    output logic                             done,
    output logic [rhsm_pkg::HASH_W-1:0]      rem
);
    import rhsm_pkg::*;

    localparam int CW = $clog2(RED_W);

    logic [RED_W-1:0]  x_reg;
    logic [HASH_W-1:0] r_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [HASH_W:0]   cand;
    logic [HASH_W:0]   diff;
    logic [HASH_W-1:0] r_next;

    always_comb
    begin
        cand = {r_reg, x_reg[RED_W-1]};
        diff = cand - {1'b0, q};
        if (cand >= {1'b0, q})
        begin
            r_next = diff[HASH_W-1:0];
        end
        else
        begin
            r_next = cand[HASH_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(RED_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg <= {x_reg[RED_W-2:0], 1'b0};
            r_reg <= r_next;
        end
    end

    assign done = done_reg;
    assign rem  = r_reg;

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Testbench for rolling_hash_string_matcher: directed and random words against a built-in predictor.
`timescale 1ns / 100ps

module tb;
    import rhsm_pkg::*;

    localparam int PAT_DEPTH  = 64;
    localparam int TEXT_CAP   = 65536;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_LEN   = 600;

    typedef struct packed {
        logic        found;
        logic [15:0] start;
        logic [16:0] total;
        logic [15:0] last;
        logic        any;
        logic        done;
    } match_rsp_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic [7:0]  symbol;
    logic [5:0]  pattern_index;
    logic        end_of_text;
    logic        out_valid;
    logic        out_ready;
    logic        match_found;
    logic [15:0] match_start;
    logic [16:0] match_total;
    logic [15:0] last_start;
    logic        any_match;
    logic        text_done;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    match_rsp_t rsp_pending[$];
    int         err_cnt;
    int         idle_cycles;
    bit         hold_req;

    // predictor state
    logic [7:0]  pat_mem[PAT_DEPTH];
    logic [7:0]  win_mem[PAT_DEPTH];
    longint      pat_hash, txt_hash, rad_pow, txt_pos, hit_cnt, hit_last;
    bit          hit_seen;
    longint      cur_radix, cur_mod, cur_plen;

    // pattern as loaded by the random phases, used to plant matches
    logic [7:0]  plan_pat[PAT_DEPTH];

    rolling_hash_string_matcher dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .symbol(symbol), .pattern_index(pattern_index),
        .end_of_text(end_of_text),
        .out_valid(out_valid), .out_ready(out_ready),
        .match_found(match_found), .match_start(match_start),
        .match_total(match_total), .last_start(last_start),
        .any_match(any_match), .text_done(text_done),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint sym_val(input longint code, input longint q);
        return (code % q + q - (48 % q)) % q;
    endfunction

    function automatic match_rsp_t hash_step(input func_t op, input logic [7:0] sym,
                                             input logic [5:0] pidx, input logic eot);
        match_rsp_t r;
        longint     q, m, v, t, sub, pos, st;
        bit         same;
        q = (cur_mod == 0) ? 1 : cur_mod;
        m = (cur_plen == 0) ? 1 : ((cur_plen > PAT_DEPTH) ? PAT_DEPTH : cur_plen);
        r = '0;
        if (op == FN_LOAD) begin
            pat_mem[pidx] = sym;
            if (pidx < m) begin
                v = sym_val(sym, q);
                if (pidx == 0) begin
                    pat_hash = v;
                    rad_pow  = 1 % q;
                end else begin
                    pat_hash = (cur_radix * (pat_hash % q) + v) % q;
                    rad_pow  = (cur_radix * (rad_pow % q)) % q;
                end
            end
        end else if (op == FN_RESTART) begin
            txt_hash = 0; txt_pos = 0; hit_cnt = 0; hit_last = 0; hit_seen = 0;
        end else if (op == FN_TEXT) begin
            r.done = eot;
            if (txt_pos < TEXT_CAP) begin
                pos = txt_pos;
                v = sym_val(sym, q);
                t = txt_hash % q;
                if (pos >= m) begin
                    sub = (sym_val(win_mem[(pos - m) % PAT_DEPTH], q) * (rad_pow % q)) % q;
                    t = (t + q - sub) % q;
                end
                t = (cur_radix * t + v) % q;
                txt_hash = t;
                win_mem[pos % PAT_DEPTH] = sym;
                if (pos + 1 >= m) begin
                    st = pos + 1 - m;
                    r.start = st[15:0];
                    if (t == pat_hash % q) begin
                        same = 1;
                        for (int j = 0; j < m; j++)
                            if (pat_mem[j] != win_mem[(st + j) % PAT_DEPTH]) same = 0;
                        if (same) begin
                            r.found = 1'b1;
                            if (hit_cnt < TEXT_CAP) hit_cnt++;
                            hit_last = st & 16'hFFFF;
                            hit_seen = 1;
                        end
                    end
                end
                txt_pos = pos + 1;
            end
        end
        r.total = hit_cnt[16:0];
        r.last  = hit_last[15:0];
        r.any   = hit_seen;
        return r;
    endfunction

    // acceptance bookkeeping for the watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result check
    always @(posedge clk)
    begin
        match_rsp_t exp_r;
        if (rst_n && out_valid && out_ready) begin
            if (rsp_pending.size() == 0) begin
                $error("result word with nothing expected");
                err_cnt++;
            end else begin
                exp_r = rsp_pending.pop_front();
                if (match_found !== exp_r.found) begin
                    $error("match_found exp %0d got %0d", exp_r.found, match_found); err_cnt++;
                end
                if (match_start !== exp_r.start) begin
                    $error("match_start exp %0d got %0d", exp_r.start, match_start); err_cnt++;
                end
                if (match_total !== exp_r.total) begin
                    $error("match_total exp %0d got %0d", exp_r.total, match_total); err_cnt++;
                end
                if (last_start !== exp_r.last) begin
                    $error("last_start exp %0d got %0d", exp_r.last, last_start); err_cnt++;
                end
                if (any_match !== exp_r.any) begin
                    $error("any_match exp %0d got %0d", exp_r.any, any_match); err_cnt++;
                end
                if (text_done !== exp_r.done) begin
                    $error("text_done exp %0d got %0d", exp_r.done, text_done); err_cnt++;
                end
            end
        end
    end

    // receiver: random stalls, one long hold when asked
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            gap = $urandom_range(0, 7);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (hold_req) begin
                gap = HOLD_LEN;
                hold_req = 0;
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_word(input func_t op, input logic [7:0] sym,
                             input logic [5:0] pidx, input logic eot);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        func          <= op;
        symbol        <= sym;
        pattern_index <= pidx;
        end_of_text   <= eot;
        do @(posedge clk); while (!in_ready);
        rsp_pending.push_back(hash_step(op, sym, pidx, eot));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        wait (rsp_pending.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_RADIX:   cur_radix = data & 16'h1FF;
            CFG_MODULUS: cur_mod   = data;
            CFG_PLEN:    cur_plen  = data & 16'h7F;
            default:     ;
        endcase
    endtask

    task automatic set_regs(input logic [15:0] rad, input logic [15:0] md, input logic [15:0] pl);
        drain();
        write_reg(CFG_RADIX, rad);
        write_reg(CFG_MODULUS, md);
        write_reg(CFG_PLEN, pl);
    endtask

    // every pattern entry gets written once so no compare ever reads an unset entry
    task automatic test_pattern_fill();
        for (int i = 0; i < PAT_DEPTH; i++)
            send_word(FN_LOAD, 8'($urandom_range(0, 255)), 6'(i), 1'b0);
    endtask

    task automatic test_directed();
        logic [7:0] txt[8] = '{"1", "0", "1", "0", "1", "1", "0", "1"};
        set_regs(16'd10, 16'd13, 16'd3);
        send_word(FN_LOAD, "1", 6'd0, 1'b0);
        send_word(FN_LOAD, "0", 6'd1, 1'b0);
        send_word(FN_LOAD, "1", 6'd2, 1'b0);
        send_word(FN_LOAD, 8'hFF, 6'd63, 1'b0);   // beyond length: store only
        send_word(FN_LOAD, 8'h00, 6'd5, 1'b0);
        send_word(FN_RESTART, 8'h00, 6'd0, 1'b0);
        foreach (txt[i])
            send_word(FN_TEXT, txt[i], 6'd0, 1'b0);
        send_word(FN_NOP, 8'hAA, 6'h2A, 1'b1);
        send_word(FN_TEXT, 8'hFF, 6'h3F, 1'b0);
        send_word(FN_TEXT, 8'h00, 6'd0, 1'b1);
        send_word(FN_RESTART, 8'hFF, 6'h3F, 1'b1);
        send_word(FN_TEXT, "1", 6'd0, 1'b0);
        send_word(FN_TEXT, "0", 6'd0, 1'b0);
        send_word(FN_TEXT, "1", 6'd0, 1'b1);
        drain();
        write_reg(CFG_NONE, 16'hFFFF);
    endtask

    task automatic random_phase(input logic [15:0] rad, input logic [15:0] md,
                                input logic [15:0] pl, input int n_items, input bit hold);
        int   m, k, sent;
        logic [7:0] base;
        set_regs(rad, md, pl);
        m = (pl & 16'h7F) == 0 ? 1 : (((pl & 16'h7F) > PAT_DEPTH) ? PAT_DEPTH : (pl & 16'h7F));
        base = ($urandom_range(0, 1) == 0) ? "0" : 8'($urandom_range(0, 250));
        for (int i = 0; i < m; i++) begin
            plan_pat[i] = base + 8'($urandom_range(0, 1));
            send_word(FN_LOAD, plan_pat[i], 6'(i), 1'b0);
        end
        send_word(FN_RESTART, 8'($urandom), 6'($urandom), 1'b0);
        if (hold) hold_req = 1;
        sent = 0;
        while (sent < n_items) begin
            k = $urandom_range(0, 15);
            if (k == 0) begin
                send_word(func_t'($urandom_range(0, 3)), 8'($urandom), 6'($urandom),
                          1'($urandom));
                sent++;
            end else if (k == 1 && m <= 16) begin
                // plant a full copy of the pattern
                for (int j = 0; j < m; j++)
                    send_word(FN_TEXT, plan_pat[j], 6'($urandom), 1'b0);
                sent += m;
            end else if (k == 2) begin
                send_word(FN_TEXT, 8'($urandom), 6'($urandom), 1'($urandom));
                sent++;
            end else begin
                send_word(FN_TEXT, base + 8'($urandom_range(0, 1)), 6'($urandom),
                          1'($urandom_range(0, 30) == 0));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0; func = FN_NOP; symbol = '0; pattern_index = '0; end_of_text = 1'b0;
        cfg_valid = 1'b0; cfg_index = CFG_NONE; cfg_data = '0;
        err_cnt = 0; idle_cycles = 0; hold_req = 0;
        pat_hash = 0; txt_hash = 0; rad_pow = 1; txt_pos = 0;
        hit_cnt = 0; hit_last = 0; hit_seen = 0;
        cur_radix = 10; cur_mod = 13; cur_plen = 1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pattern_fill();
        test_directed();
        random_phase(16'd10, 16'd13, 16'd1, 170, 1'b1);
        random_phase(16'd2, 16'd2, 16'd1, 170, 1'b0);
        random_phase(16'd256, 16'd65535, 16'd64, 120, 1'b0);
        random_phase(16'd0, 16'd0, 16'd0, 170, 1'b0);
        random_phase(16'd511, 16'd65535, 16'd127, 100, 1'b0);
        random_phase(16'd31, 16'd101, 16'd4, 180, 1'b1);
        random_phase(16'd2, 16'd7, 16'd2, 180, 1'b0);
        random_phase(16'd97, 16'd65521, 16'd8, 170, 1'b0);

        drain();
        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
